/* src/lse_pkg.sv */
// Shared types and constants for the LIFO stack engine.
`timescale 1ns / 1ps
`default_nettype none
package lse_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 4;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam int IN_TDATA_W = ((DATA_W + IDX_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_CHANGE = 3'd3,
    OP_DUMP   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RD   = 2'd1,
    S_DUMP = 2'd2
  } state_t;

  typedef struct packed {
    op_t                       kind;
    logic signed [DATA_W-1:0]  value;
    logic        [IDX_W-1:0]   index;
  } cmd_t;

  // queue handshake between front and back
  typedef struct packed {
    logic wr;
    logic rd;
  } q_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

/* src/lse_front.sv */
// Front end: accepts input words, decodes the op and queues valid commands.
`timescale 1ns / 1ps
`default_nettype none
module lse_front
  import lse_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,  // value[31:0], index[35:32], zero pad
  input  wire logic [2:0]            in_tuser,  // op
  input  wire q_stat_t               q_stat,
  output logic                       q_wr,
  output cmd_t                       q_cmd
);

  logic op_known;
  logic accept;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  // unknown op codes are taken and dropped, nothing is queued
  always_comb begin
    case (in_tuser)
      OP_PUSH, OP_POP, OP_PEEK, OP_CHANGE, OP_DUMP: op_known = 1'b1;
      default:                                      op_known = 1'b0;
    endcase
  end

  assign q_wr        = accept && op_known;
  assign q_cmd.kind  = op_t'(in_tuser);
  assign q_cmd.value = in_tdata[DATA_W-1:0];
  assign q_cmd.index = in_tdata[DATA_W+IDX_W-1:DATA_W];

  always_ff @(posedge clk) begin
    if (rst_n) begin
      assert (!(q_wr && q_stat.full)) else $error("front wrote a full queue");
    end
  end

  a_ready_tracks_queue: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !in_tready)
    else $error("front ready while queue full");

  a_drop_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser > 3'(OP_DUMP)) |-> !q_wr)
    else $error("unknown op queued");

  a_known_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op_known) |-> q_wr)
    else $error("known op lost");

endmodule
`default_nettype wire

/* src/lse_queue.sv */
// Short command queue between the front end and the stack back end.
`timescale 1ns / 1ps
`default_nettype none
module lse_queue
  import lse_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire q_ctl_t  ctl,
  input  wire cmd_t    wr_cmd,
  output cmd_t         rd_cmd,
  output q_stat_t      stat
);

  cmd_t              slot_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] fill_r, fill_nxt;

  assign stat.full  = (fill_r == QCNT_W'(Q_DEPTH));
  assign stat.empty = (fill_r == '0);
  assign rd_cmd     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (ctl.wr) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (ctl.rd) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    case ({ctl.wr, ctl.rd})
      2'b10:   fill_nxt = fill_r + QCNT_W'(1);
      2'b01:   fill_nxt = fill_r - QCNT_W'(1);
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.wr && stat.full))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.rd && stat.empty))
    else $error("queue underflow");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= QCNT_W'(Q_DEPTH))
    else $error("queue fill out of range");

endmodule
`default_nettype wire

/* src/lse_back.sv */
// Back end: runs stack commands against the entry memory and drives the result register.
`timescale 1ns / 1ps
`default_nettype none
module lse_back
  import lse_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  input  wire logic               cmd_avail,
  output logic                    cmd_take,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [DATA_W-1:0]       out_tdata,
  output logic [1:0]              out_tuser,
  output logic                    out_tlast
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_data_r;
  status_t                  out_status_r;
  logic                     out_last_r;

  logic                     can_load;
  logic                     load;
  logic signed [DATA_W-1:0] load_data;
  status_t                  load_status;
  logic                     load_last;
  logic                     mem_we, mem_re;
  logic [PTR_W-1:0]         waddr, raddr;
  logic                     is_empty, is_full, idx_ok, dump_last;
  logic [PTR_W-1:0]         top;

  assign can_load  = !out_valid_r || out_tready;
  assign cmd_take  = (state_r == S_IDLE) && cmd_avail && can_load;
  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == CNT_W'(DEPTH));
  assign idx_ok    = CMP_W'(cmd.index) < CMP_W'(count_r);
  assign top       = PTR_W'(count_r - CNT_W'(1));
  assign dump_last = (CNT_W'(ptr_r) + CNT_W'(1)) == count_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_take) begin
          case (cmd.kind)
            OP_POP, OP_PEEK: state_nxt = is_empty ? S_IDLE : S_RD;
            OP_DUMP:         state_nxt = is_empty ? S_IDLE : S_DUMP;
            default:         state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        if (can_load) state_nxt = S_IDLE;
      end
      S_DUMP: begin
        if (can_load && dump_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    load        = 1'b0;
    load_data   = '0;
    load_status = ST_OK;
    load_last   = 1'b1;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    waddr       = top;
    raddr       = top;
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_take) begin
          case (cmd.kind)
            OP_PUSH: begin
              load = 1'b1;
              if (is_full) begin
                load_status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                waddr     = PTR_W'(count_r);
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_POP, OP_PEEK: begin
              if (is_empty) begin
                load        = 1'b1;
                load_status = ST_EMPTY;
              end else begin
                mem_re = 1'b1;
                if (cmd.kind == OP_POP) count_nxt = count_r - CNT_W'(1);
              end
            end
            OP_CHANGE: begin
              load = 1'b1;
              if (idx_ok) begin
                mem_we = 1'b1;
                waddr  = PTR_W'(cmd.index);
              end else begin
                load_status = ST_BADIDX;
              end
            end
            OP_DUMP: begin
              if (is_empty) begin
                load        = 1'b1;
                load_status = ST_EMPTY;
              end else begin
                mem_re  = 1'b1;
                raddr   = '0;
                ptr_nxt = '0;
              end
            end
            default: load = 1'b0;
          endcase
        end
      end
      S_RD: begin
        if (can_load) begin
          load      = 1'b1;
          load_data = rd_data_r;
        end
      end
      S_DUMP: begin
        if (can_load) begin
          load      = 1'b1;
          load_data = rd_data_r;
          load_last = dump_last;
          if (!dump_last) begin
            ptr_nxt = ptr_r + PTR_W'(1);
            mem_re  = 1'b1;
            raddr   = ptr_r + PTR_W'(1);
          end
        end
      end
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r   <= load_data;
      out_status_r <= load_status;
      out_last_r   <= load_last;
    end
  end

  // entry memory, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= cmd.value;
    end
    if (mem_re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("stack count past depth");

  a_dump_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> (CNT_W'(ptr_r) < count_r))
    else $error("dump pointer past top");

  a_nonlast_only_dump: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !load_last) |-> (state_r == S_DUMP))
    else $error("non-final word outside dump");

  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !load)
    else $error("result register overwritten while stalled");

endmodule
`default_nettype wire

/* src/lifo_stack_engine.sv */
// Top level of the LIFO stack engine: front end, command queue and back end.
//
// Usage: each word on the in_ channel carries one stack op in in_tuser (push, pop,
// peek, change, dump) with value and index in in_tdata. Words with an unknown op
// are accepted and produce no result. Results leave on the out_ channel: the data
// word in out_tdata, the status in out_tuser, out_tlast set on the final word
// caused by an input word. Push, pop, peek and change give one result each; dump
// gives one word per stored entry, bottom first, or one empty result.
// Push, change and error results go from acceptance through the queue, then the
// result register; pop and peek add the registered read of the entry memory. The
// back end takes one command per cycle for push, change and errors while the result
// register can load; pop and peek hold it in its read state before the next one.
// Dump words stream one per cycle while the receiver keeps up. The queue holds two
// words, so the input keeps taking words while the back end or the receiver is
// busy. Reset empties the stack and the queue; entry contents are not cleared.
// When the receiver stalls, the result register holds its word, the back end
// stops, the queue fills and then in_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module lifo_stack_engine
  import lse_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,   // value[31:0], index[35:32], zero pad
  input  wire logic [2:0]            in_tuser,   // op
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [DATA_W-1:0]          out_tdata,  // data[31:0]
  output logic [1:0]                 out_tuser,  // status
  output logic                       out_tlast
);

  q_ctl_t  q_ctl;
  q_stat_t q_stat;
  cmd_t    wr_cmd;
  cmd_t    rd_cmd;

  lse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .q_wr      (q_ctl.wr),
    .q_cmd     (wr_cmd)
  );

  lse_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (q_ctl),
    .wr_cmd (wr_cmd),
    .rd_cmd (rd_cmd),
    .stat   (q_stat)
  );

  lse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (rd_cmd),
    .cmd_avail  (!q_stat.empty),
    .cmd_take   (q_ctl.rd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the LIFO stack engine: directed corner cases, then random traffic.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import lse_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    status_t                  status;
    logic                     last;
  } result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  wire                   in_tready;
  logic [IN_TDATA_W-1:0] in_tdata   = '0;
  logic [2:0]            in_tuser   = '0;
  wire                   out_tvalid;
  logic                  out_tready = 1'b0;
  wire  [DATA_W-1:0]     out_tdata;
  wire  [1:0]            out_tuser;
  wire                   out_tlast;

  lifo_stack_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow stack and the words it says must come out, oldest first
  logic signed [DATA_W-1:0] stack_words [DEPTH];
  int                       stack_fill = 0;
  result_t                  expected_results [$];

  bit idle_on       = 1'b0;
  int mismatch_cnt  = 0;
  int words_checked = 0;
  int idle_cycles   = 0;
  int ops_by_code [8];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  function automatic void queue_result(input logic signed [DATA_W-1:0] data,
                                       input status_t status, input logic last);
    result_t r;
    r.data   = data;
    r.status = status;
    r.last   = last;
    expected_results.push_back(r);
  endfunction

  task automatic predict_stack_op(input logic [2:0] op, input logic signed [DATA_W-1:0] value,
                                  input logic [IDX_W-1:0] idx);
    ops_by_code[op]++;
    case (op)
      OP_PUSH: begin
        if (stack_fill >= DEPTH) begin
          queue_result('0, ST_FULL, 1'b1);
        end else begin
          stack_words[stack_fill] = value;
          stack_fill++;
          queue_result('0, ST_OK, 1'b1);
        end
      end
      OP_POP: begin
        if (stack_fill == 0) begin
          queue_result('0, ST_EMPTY, 1'b1);
        end else begin
          stack_fill--;
          queue_result(stack_words[stack_fill], ST_OK, 1'b1);
        end
      end
      OP_PEEK: begin
        if (stack_fill == 0) queue_result('0, ST_EMPTY, 1'b1);
        else queue_result(stack_words[stack_fill-1], ST_OK, 1'b1);
      end
      OP_CHANGE: begin
        if (int'(idx) >= stack_fill) begin
          queue_result('0, ST_BADIDX, 1'b1);
        end else begin
          stack_words[idx] = value;
          queue_result('0, ST_OK, 1'b1);
        end
      end
      OP_DUMP: begin
        if (stack_fill == 0) begin
          queue_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < stack_fill; i++)
            queue_result(stack_words[i], ST_OK, (i == stack_fill - 1));
        end
      end
      default: ;  // unused codes: accepted, no result
    endcase
  endtask

  // one word on the input channel; prediction happens at the accepting edge
  task automatic send_word(input logic [2:0] op, input logic signed [DATA_W-1:0] value,
                           input logic [IDX_W-1:0] idx);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_TDATA_W-DATA_W-IDX_W){1'b0}}, idx, value};
    do @(posedge clk); while (!in_tready);
    predict_stack_op(op, value, idx);
  endtask

  // hold off the sender until every predicted word has come out
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_word();
    if ($urandom_range(0, 7) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  task automatic test_empty_stack();
    idle_on = 1'b0;
    send_word(OP_POP, rand_word(), '0);
    send_word(OP_PEEK, rand_word(), '0);
    send_word(OP_DUMP, rand_word(), '0);
    send_word(OP_CHANGE, 32'sh1234_5678, '0);
    // codes past dump must be swallowed
    send_word(3'd5, rand_word(), 4'hf);
    send_word(3'd6, rand_word(), 4'h0);
    send_word(3'd7, rand_word(), 4'ha);
    drain_results();
  endtask

  task automatic test_fill_to_full();
    idle_on = 1'b1;
    send_word(OP_PUSH, 32'sh8000_0000, '0);
    send_word(OP_PUSH, 32'sh7fff_ffff, '0);
    send_word(OP_PUSH, '0, '0);
    send_word(OP_PUSH, '1, '0);
    for (int i = 4; i < DEPTH; i++) send_word(OP_PUSH, rand_word(), '0);
    send_word(OP_PUSH, 32'sh5a5a_a5a5, '0);  // stack full
  endtask

  task automatic test_change_and_dump();
    idle_on = 1'b1;
    send_word(OP_CHANGE, 32'sh0bad_cafe, '0);
    send_word(OP_CHANGE, 32'sh7fff_ffff, 4'hf);
    send_word(OP_DUMP, '0, '0);
    send_word(OP_POP, '0, '0);
    send_word(OP_CHANGE, '1, 4'hf);  // top slot just freed
    drain_results();
  endtask

  task automatic run_random_mix(input int n_items, input int push_pct, input int pop_pct);
    int                       counted;
    int                       r;
    logic [2:0]               op;
    logic [IDX_W-1:0]         idx;
    counted = 0;
    while (counted < n_items) begin
      r   = $urandom_range(0, 99);
      idx = IDX_W'($urandom_range(0, 15));
      if (r < push_pct) begin
        op = OP_PUSH;
      end else if (r < push_pct + pop_pct) begin
        op = OP_POP;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: op = OP_PEEK;
          3, 4, 5: begin
            op = OP_CHANGE;
            if (stack_fill > 0 && $urandom_range(0, 3) != 0)
              idx = IDX_W'($urandom_range(0, stack_fill - 1));
          end
          6, 7, 8: op = OP_DUMP;
          default: op = 3'($urandom_range(5, 7));
        endcase
      end
      send_word(op, rand_word(), idx);
      if (op <= OP_DUMP) counted++;
    end
  endtask

  task automatic test_random_traffic();
    idle_on = 1'b1;
    run_random_mix(20, 60, 10);
    idle_on = 1'b0;
    run_random_mix(20, 10, 60);
    drain_results();
    idle_on = 1'b1;
    run_random_mix(20, 35, 35);
    run_random_mix(20, 70, 10);
  endtask

  // receiver: random stall before taking each word
  initial begin : receiver
    int stall;
    wait (rst_n);
    forever begin
      @(negedge clk);
      stall = idle_on ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      words_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word data=%h status=%0d last=%0b",
                                  out_tdata, out_tuser, out_tlast));
      end else begin
        want = expected_results.pop_front();
        if (out_tdata !== want.data)
          report_mismatch($sformatf("data %h, want %h", out_tdata, want.data));
        if (out_tuser !== want.status)
          report_mismatch($sformatf("status %0d, want %s", out_tuser, want.status.name()));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", out_tlast, want.last));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[%0t] no traffic for %0d cycles, %0d words outstanding",
                 $time, idle_cycles, expected_results.size());
        $display("lifo_stack_engine regression: fail");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) ops_by_code[i] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_stack();
    test_fill_to_full();
    test_change_and_dump();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ops sent: push %0d, pop %0d, peek %0d, change %0d, dump %0d, unused codes %0d",
             ops_by_code[OP_PUSH], ops_by_code[OP_POP], ops_by_code[OP_PEEK],
             ops_by_code[OP_CHANGE], ops_by_code[OP_DUMP],
             ops_by_code[5] + ops_by_code[6] + ops_by_code[7]);
    $display("result words checked: %0d, mismatches: %0d", words_checked, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("lifo_stack_engine regression: pass");
    end else begin
      $display("lifo_stack_engine regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
